// File: sv/first_fit_free_segment_allocator_top_defines.svh
// Assertion macros shared by the first-fit free segment allocator RTL
`ifndef FIRST_FIT_FREE_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_FREE_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset
`define FFSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffsa assertion failed");

// Next-cycle implication, checked on clk, off during reset
`define FFSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsa assertion failed");

`endif

// File: sv/ffsa_pkg.sv
// Shared constants, codes and controller/datapath interface types
package ffsa_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int ADDR_BITS   = 32;
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_FREE  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_ALLOC   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOFIT   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_MERGED  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_STORED  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_DROPPED = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_CLEARED = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic                   load;
        logic                   scan;
        logic                   store;
        logic                   clear_tbl;
        logic                   result_load;
        logic [STATUS_BITS-1:0] res_status;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_BITS-1:0] op;
        logic                inverted;
        logic                req_zero;
        logic                hit;
        logic                last;
        logic                empty_here;
        logic                empty_found;
        logic                out_free;
    } dp_status_t;

endpackage

// File: sv/first_fit_free_segment_allocator_top.sv
// Top level of the first-fit free segment allocator
// A command is taken only when the block is idle and runs alone: a transfer on the request
// side is followed by a decode state, then a scan of the 16-slot table at one slot per
// cycle, then a finish state that loads the result register once it is free. Clear,
// unknown commands, inverted frees and zero-size allocations skip the scan; a free or
// allocate stops at the first slot that hits, and a miss scans all 16. The single slot read
// port of the table sets the scan length. The result register decouples the two sides, so
// a new request is taken while the previous result still waits on the response side.
module first_fit_free_segment_allocator_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic [ffsa_pkg::CMD_BITS-1:0]         cmd,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]        seg_begin,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]        seg_end,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]        request_size,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic [ffsa_pkg::STATUS_BITS-1:0]      status,
    output logic [ffsa_pkg::ADDR_BITS-1:0]        alloc_begin,
    output logic [ffsa_pkg::ADDR_BITS-1:0]        alloc_end
);

    ffsa_pkg::ctrl_cmd_t  ctl;
    ffsa_pkg::dp_status_t sts;

    // Sequencer
    ffsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Table and result path
    ffsa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .seg_begin    (seg_begin),
        .seg_end      (seg_end),
        .request_size (request_size),
        .ctl          (ctl),
        .sts          (sts),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .alloc_begin  (alloc_begin),
        .alloc_end    (alloc_end)
    );

endmodule

// File: sv/ffsa_datapath.sv
// Segment table, scan pointer, per-slot match logic and result register
module ffsa_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [ffsa_pkg::CMD_BITS-1:0]         cmd,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]        seg_begin,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]        seg_end,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]        request_size,
    input  ffsa_pkg::ctrl_cmd_t                   ctl,
    output ffsa_pkg::dp_status_t                  sts,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic [ffsa_pkg::STATUS_BITS-1:0]      status,
    output logic [ffsa_pkg::ADDR_BITS-1:0]        alloc_begin,
    output logic [ffsa_pkg::ADDR_BITS-1:0]        alloc_end
);

    // Captured item
    logic [ffsa_pkg::CMD_BITS-1:0]  op_reg;
    logic [ffsa_pkg::ADDR_BITS-1:0] fb_reg;
    logic [ffsa_pkg::ADDR_BITS-1:0] fe_reg;
    logic [ffsa_pkg::ADDR_BITS-1:0] reqm1_reg;
    logic                           req_zero_reg;
    logic                           inverted_reg;

    // Scan state
    logic [ffsa_pkg::SLOT_BITS-1:0] idx_reg;
    logic                           empty_found_reg;
    logic [ffsa_pkg::SLOT_BITS-1:0] empty_idx_reg;

    // Table
    logic [ffsa_pkg::SLOTS-1:0]     slot_valid_reg;
    logic [ffsa_pkg::ADDR_BITS-1:0] slot_begin_reg [ffsa_pkg::SLOTS];
    logic [ffsa_pkg::ADDR_BITS-1:0] slot_end_reg   [ffsa_pkg::SLOTS];

    // Allocation result and output register
    logic [ffsa_pkg::ADDR_BITS-1:0]   ab_reg;
    logic [ffsa_pkg::ADDR_BITS-1:0]   ae_reg;
    logic                             rsp_valid_reg;
    logic [ffsa_pkg::STATUS_BITS-1:0] status_reg;
    logic [ffsa_pkg::ADDR_BITS-1:0]   alloc_begin_reg;
    logic [ffsa_pkg::ADDR_BITS-1:0]   alloc_end_reg;

    // Slot under the scan pointer
    logic                           cur_valid;
    logic [ffsa_pkg::ADDR_BITS-1:0] cur_b;
    logic [ffsa_pkg::ADDR_BITS-1:0] cur_e;
    logic                           end_adj;
    logic                           begin_adj;
    logic [ffsa_pkg::ADDR_BITS-1:0] span;
    logic                           fit;
    logic                           exact;
    logic [ffsa_pkg::ADDR_BITS-1:0] alloc_last;
    logic [ffsa_pkg::ADDR_BITS-1:0] rest_begin;
    logic                           hit;
    logic [ffsa_pkg::SLOT_BITS-1:0] store_idx;
    logic                           last;

    assign cur_valid = slot_valid_reg[idx_reg];
    assign cur_b     = slot_begin_reg[idx_reg];
    assign cur_e     = slot_end_reg[idx_reg];

    // Adjacency, no wrap at either end of the address space
    assign end_adj   = (cur_e != '1) &&
                       (ffsa_pkg::ADDR_BITS'(cur_e + ffsa_pkg::ADDR_BITS'(1)) == fb_reg);
    assign begin_adj = (cur_b != '0) &&
                       (ffsa_pkg::ADDR_BITS'(cur_b - ffsa_pkg::ADDR_BITS'(1)) == fe_reg);

    // Fit test against size minus one
    assign span       = cur_e - cur_b;
    assign fit        = span >= reqm1_reg;
    assign exact      = span == reqm1_reg;
    assign alloc_last = cur_b + reqm1_reg;
    assign rest_begin = alloc_last + ffsa_pkg::ADDR_BITS'(1);

    always_comb
    begin
        case (op_reg)
            ffsa_pkg::CMD_FREE:  hit = cur_valid && (end_adj || begin_adj);
            ffsa_pkg::CMD_ALLOC: hit = cur_valid && fit;
            default:             hit = 1'b0;
        endcase
    end

    assign last      = idx_reg == ffsa_pkg::SLOT_BITS'(ffsa_pkg::SLOTS - 1);
    assign store_idx = empty_found_reg ? empty_idx_reg : idx_reg;

    // Status to the controller
    assign sts.op          = op_reg;
    assign sts.inverted    = inverted_reg;
    assign sts.req_zero    = req_zero_reg;
    assign sts.hit         = hit;
    assign sts.last        = last;
    assign sts.empty_here  = !cur_valid;
    assign sts.empty_found = empty_found_reg;
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    // Item capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg       <= cmd;
            fb_reg       <= seg_begin;
            fe_reg       <= seg_end;
            reqm1_reg    <= request_size - ffsa_pkg::ADDR_BITS'(1);
            req_zero_reg <= request_size == '0;
            inverted_reg <= seg_end < seg_begin;
        end
    end

    // Scan pointer and first empty slot seen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
        end
        else if (ctl.load)
        begin
            idx_reg         <= '0;
            empty_found_reg <= 1'b0;
        end
        else if (ctl.scan && !hit)
        begin
            idx_reg <= idx_reg + ffsa_pkg::SLOT_BITS'(1);
            if (!cur_valid && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= idx_reg;
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (ctl.clear_tbl)
        begin
            slot_valid_reg <= '0;
        end
        else
        begin
            if (ctl.scan && hit && op_reg == ffsa_pkg::CMD_ALLOC && exact)
                slot_valid_reg[idx_reg] <= 1'b0;
            if (ctl.store)
                slot_valid_reg[store_idx] <= 1'b1;
        end
    end

    // Segment bounds and allocation capture
    always_ff @(posedge clk)
    begin
        if (ctl.scan && hit)
        begin
            if (op_reg == ffsa_pkg::CMD_FREE)
            begin
                if (end_adj)
                    slot_end_reg[idx_reg] <= fe_reg;
                if (begin_adj)
                    slot_begin_reg[idx_reg] <= fb_reg;
            end
            else
            begin
                ab_reg <= cur_b;
                ae_reg <= alloc_last;
                if (!exact)
                    slot_begin_reg[idx_reg] <= rest_begin;
            end
        end
        if (ctl.store)
        begin
            slot_begin_reg[store_idx] <= fb_reg;
            slot_end_reg[store_idx]   <= fe_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (ctl.result_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.result_load)
        begin
            status_reg <= ctl.res_status;
            if (ctl.res_status == ffsa_pkg::ST_ALLOC)
            begin
                alloc_begin_reg <= ab_reg;
                alloc_end_reg   <= ae_reg;
            end
            else
            begin
                alloc_begin_reg <= '0;
                alloc_end_reg   <= '0;
            end
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign alloc_begin = alloc_begin_reg;
    assign alloc_end   = alloc_end_reg;

endmodule

// File: sv/ffsa_ctrl.sv
// Command sequencer: decode, slot scan and result hand-off
`include "first_fit_free_segment_allocator_top_defines.svh"

module ffsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ffsa_pkg::dp_status_t sts,
    output ffsa_pkg::ctrl_cmd_t  ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [ffsa_pkg::STATUS_BITS-1:0] res_reg;
    logic [ffsa_pkg::STATUS_BITS-1:0] res_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        req_ready      = 1'b0;
        ctl            = '0;
        ctl.res_status = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    ffsa_pkg::CMD_FREE:
                    begin
                        if (sts.inverted)
                        begin
                            res_next   = ffsa_pkg::ST_DROPPED;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    ffsa_pkg::CMD_ALLOC:
                    begin
                        if (sts.req_zero)
                        begin
                            res_next   = ffsa_pkg::ST_NOFIT;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    ffsa_pkg::CMD_CLEAR:
                    begin
                        ctl.clear_tbl = 1'b1;
                        res_next      = ffsa_pkg::ST_CLEARED;
                        state_next    = S_FINISH;
                    end
                    default:
                    begin
                        res_next   = ffsa_pkg::ST_NOFIT;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.hit)
                begin
                    res_next   = (sts.op == ffsa_pkg::CMD_FREE) ? ffsa_pkg::ST_MERGED
                                                                 : ffsa_pkg::ST_ALLOC;
                    state_next = S_FINISH;
                end
                else if (sts.last)
                begin
                    if (sts.op == ffsa_pkg::CMD_FREE)
                    begin
                        if (sts.empty_found || sts.empty_here)
                        begin
                            ctl.store = 1'b1;
                            res_next  = ffsa_pkg::ST_STORED;
                        end
                        else
                        begin
                            res_next = ffsa_pkg::ST_DROPPED;
                        end
                    end
                    else
                    begin
                        res_next = ffsa_pkg::ST_NOFIT;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= ffsa_pkg::ST_NOFIT;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // Checks
    `FFSA_ASSERT_NOW(a_result_into_free_reg, ctl.result_load, sts.out_free)
    `FFSA_ASSERT_NEXT(a_hit_ends_scan, (state_reg == S_SCAN) && sts.hit, state_reg == S_FINISH)
    `FFSA_ASSERT_NEXT(a_transfer_to_decode, req_valid && req_ready, state_reg == S_DECODE)
    `FFSA_ASSERT_NOW(a_store_only_on_free, ctl.store, sts.op == ffsa_pkg::CMD_FREE)

endmodule

// File: dv/ffsa_checker.sv
// Checker for the first-fit free segment allocator: predicts each result and compares
`timescale 1ns / 1ps

module ffsa_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_ready,
    input  logic [ffsa_pkg::CMD_BITS-1:0]     cmd,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]    seg_begin,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]    seg_end,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]    request_size,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic [ffsa_pkg::STATUS_BITS-1:0]  status,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]    alloc_begin,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]    alloc_end,
    output int                                fail_count,
    output int                                pending
);
    import ffsa_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] st;
        logic [ADDR_BITS-1:0]   lo;
        logic [ADDR_BITS-1:0]   hi;
    } outcome_t;

    // Shadow copy of the free table
    logic                 seg_live [SLOTS];
    logic [ADDR_BITS-1:0] seg_lo   [SLOTS];
    logic [ADDR_BITS-1:0] seg_hi   [SLOTS];

    outcome_t due_outcomes [$];

    // Applies one command to the shadow table and returns the result it gives
    function automatic outcome_t table_outcome(input logic [CMD_BITS-1:0] op,
                                               input logic [ADDR_BITS-1:0] b,
                                               input logic [ADDR_BITS-1:0] e,
                                               input logic [ADDR_BITS-1:0] sz);
        outcome_t             r;
        logic [ADDR_BITS-1:0] span;
        logic                 hit;
        logic                 done;
        int                   i;
        r    = '{st: ST_NOFIT, lo: '0, hi: '0};
        done = 1'b0;
        case (op)
            CMD_FREE:
            begin
                r.st = ST_DROPPED;
                if (e >= b)
                begin
                    // first touching slot grows; no wrap at either end of the space
                    for (i = 0; i < SLOTS && !done; i++)
                    begin
                        if (seg_live[i])
                        begin
                            hit = 1'b0;
                            if (seg_hi[i] != '1 && seg_hi[i] + 1'b1 == b)
                            begin
                                seg_hi[i] = e;
                                hit       = 1'b1;
                            end
                            if (seg_lo[i] != '0 && seg_lo[i] - 1'b1 == e)
                            begin
                                seg_lo[i] = b;
                                hit       = 1'b1;
                            end
                            if (hit)
                            begin
                                r.st = ST_MERGED;
                                done = 1'b1;
                            end
                        end
                    end
                    // otherwise lowest empty slot, or dropped when full
                    for (i = 0; i < SLOTS && !done; i++)
                    begin
                        if (!seg_live[i])
                        begin
                            seg_live[i] = 1'b1;
                            seg_lo[i]   = b;
                            seg_hi[i]   = e;
                            r.st        = ST_STORED;
                            done        = 1'b1;
                        end
                    end
                end
            end
            CMD_ALLOC:
            begin
                if (sz != '0)
                begin
                    for (i = 0; i < SLOTS && !done; i++)
                    begin
                        if (seg_live[i])
                        begin
                            span = seg_hi[i] - seg_lo[i];
                            if (span >= sz - 1'b1)
                            begin
                                r.st = ST_ALLOC;
                                r.lo = seg_lo[i];
                                r.hi = seg_lo[i] + (sz - 1'b1);
                                if (span == sz - 1'b1)
                                    seg_live[i] = 1'b0;
                                else
                                    seg_lo[i] = r.hi + 1'b1;
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                for (i = 0; i < SLOTS; i++)
                    seg_live[i] = 1'b0;
                r.st = ST_CLEARED;
            end
            default:
                r.st = ST_NOFIT;
        endcase
        return r;
    endfunction

    // Compare finished transfers, then predict newly taken commands
    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        int       i;
        if (!rst_n)
        begin
            for (i = 0; i < SLOTS; i++)
                seg_live[i] = 1'b0;
            due_outcomes.delete();
            pending = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_outcomes.size() == 0)
                begin
                    $display("%0t: result with none due: status %0d begin %h end %h",
                             $time, status, alloc_begin, alloc_end);
                    fail_count++;
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.st, status);
                        fail_count++;
                    end
                    if (alloc_begin !== want.lo)
                    begin
                        $display("%0t: alloc_begin expected %h got %h",
                                 $time, want.lo, alloc_begin);
                        fail_count++;
                    end
                    if (alloc_end !== want.hi)
                    begin
                        $display("%0t: alloc_end expected %h got %h",
                                 $time, want.hi, alloc_end);
                        fail_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                due_outcomes.insert(due_outcomes.size(),
                                    table_outcome(cmd, seg_begin, seg_end, request_size));
            pending = due_outcomes.size();
        end
    end

endmodule

// File: dv/tb.sv
// Testbench top for the first-fit free segment allocator: stimulus, clock and verdict
`timescale 1ns / 1ps

module tb;
    import ffsa_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;  // unused code, block answers no fit
    localparam int ITEM_TARGET  = 850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_ready;
    logic [CMD_BITS-1:0]    cmd;
    logic [ADDR_BITS-1:0]   seg_begin;
    logic [ADDR_BITS-1:0]   seg_end;
    logic [ADDR_BITS-1:0]   request_size;
    logic                   rsp_valid;
    logic                   rsp_ready;
    logic [STATUS_BITS-1:0] status;
    logic [ADDR_BITS-1:0]   alloc_begin;
    logic [ADDR_BITS-1:0]   alloc_end;

    int fail_count;
    int pending;
    int cycles;
    int sent;
    int send_calm;
    int sink_calm;

    first_fit_free_segment_allocator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .cmd          (cmd),
        .seg_begin    (seg_begin),
        .seg_end      (seg_end),
        .request_size (request_size),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .alloc_begin  (alloc_begin),
        .alloc_end    (alloc_end)
    );

    ffsa_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .cmd          (cmd),
        .seg_begin    (seg_begin),
        .seg_end      (seg_end),
        .request_size (request_size),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .alloc_begin  (alloc_begin),
        .alloc_end    (alloc_end),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("first_fit_free_segment_allocator_top regression: fail");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long, with calm stretches
    function automatic int pick_pause(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Response side back-pressure
    initial
    begin : sink
        int hold;
        int n;
        rsp_ready = 1'b0;
        hold      = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                n = pick_pause(sink_calm);
                if (n > 0)
                begin
                    rsp_ready <= 1'b0;
                    hold = n - 1;
                end
                else
                    rsp_ready <= 1'b1;
            end
        end
    end

    // One request transfer, then a random gap
    task automatic send(input logic [CMD_BITS-1:0] c, input logic [ADDR_BITS-1:0] b,
                        input logic [ADDR_BITS-1:0] e, input logic [ADDR_BITS-1:0] sz);
        int n;
        @(negedge clk);
        req_valid    <= 1'b1;
        cmd          <= c;
        seg_begin    <= b;
        seg_end      <= e;
        request_size <= sz;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (c != CMD_NONE)
            sent++;
        n = pick_pause(send_calm);
        if (n > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic free_seg(input logic [ADDR_BITS-1:0] b, input logic [ADDR_BITS-1:0] e);
        send(CMD_FREE, b, e, $urandom);
    endtask

    task automatic take(input logic [ADDR_BITS-1:0] sz);
        send(CMD_ALLOC, $urandom, $urandom, sz);
    endtask

    // Hold off new commands until every result is back
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] lo;
        int                   kind;
        int                   j;
        int                   cnt;
        int                   sz;
        int                   idx;
        int                   next_pause;
        logic                 up;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        cmd          = CMD_FREE;
        seg_begin    = '0;
        seg_end      = '0;
        request_size = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, zero request, inverted free, merges on both sides,
        // no wrap at the ends, exact fit, full-range segment, no coalescing of neighbours
        send(CMD_NONE, $urandom, $urandom, $urandom);
        take(32'd1);
        take(32'd0);
        free_seg(32'd10, 32'd5);
        free_seg(32'd100, 32'd199);
        free_seg(32'd200, 32'd299);
        free_seg(32'd50, 32'd99);
        free_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        free_seg(32'd0, 32'd0);
        free_seg(32'd1, 32'd9);
        free_seg(32'hFFFF_FFF0, 32'hFFFF_FFFE);
        take(32'd250);
        take(32'd4);
        take(32'hFFFF_FFFF);
        free_seg(32'd1000, 32'd1999);
        send(CMD_CLEAR, $urandom, $urandom, $urandom);
        free_seg(32'd0, 32'hFFFF_FFFF);
        take(32'hFFFF_FFFF);
        take(32'd1);
        free_seg(32'd5, 32'd5);
        free_seg(32'd7, 32'd7);
        free_seg(32'd6, 32'd6);
        take(32'd3);
        take(32'd2);
        send(CMD_CLEAR, $urandom, $urandom, $urandom);
        wait_idle();

        // Random sequences, mostly well-formed traffic on a small grid
        next_pause = 300;
        while (sent < ITEM_TARGET)
        begin
            if (sent >= next_pause)
            begin
                wait_idle();
                next_pause += 300;
            end
            kind = $urandom_range(0, 99);
            base = $urandom & 32'hFFFF_F000;
            if (kind < 45)
            begin
                // churn of frees and allocations in one region
                cnt = $urandom_range(8, 20);
                for (j = 0; j < cnt; j++)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        idx = $urandom_range(0, 63);
                        free_seg(base + 16 * idx, base + 16 * (idx + $urandom_range(1, 4)) - 1);
                    end
                    else if ($urandom_range(0, 1) == 1)
                        take(16 * $urandom_range(1, 4));
                    else
                        take($urandom_range(1, 80));
                end
            end
            else if (kind < 60)
            begin
                // fill the table past its size, then empty some slots exactly
                send(CMD_CLEAR, $urandom, $urandom, $urandom);
                cnt = SLOTS + $urandom_range(1, 3);
                for (j = 0; j < cnt; j++)
                    free_seg(base + 32 * j, base + 32 * j + 15);
                cnt = $urandom_range(1, 4);
                for (j = 0; j < cnt; j++)
                    take(($urandom_range(0, 1) == 1) ? 16 : $urandom_range(1, 20));
            end
            else if (kind < 70)
            begin
                // contiguous chunks freed in rising or falling order
                cnt = $urandom_range(3, 10);
                sz  = $urandom_range(1, 32);
                up  = ($urandom_range(0, 1) == 1);
                for (j = 0; j < cnt; j++)
                begin
                    idx = up ? j : cnt - 1 - j;
                    free_seg(base + idx * sz, base + idx * sz + sz - 1);
                end
                take(sz * cnt);
            end
            else if (kind < 80)
            begin
                // drain with assorted sizes
                cnt = $urandom_range(3, 10);
                for (j = 0; j < cnt; j++)
                    take(($urandom_range(0, 3) == 0) ? 16 * $urandom_range(1, 8)
                                                     : $urandom_range(1, 128));
            end
            else if (kind < 90)
            begin
                // segments at the bottom and top of the address space
                lo = $urandom_range(0, 40);
                free_seg(lo, lo + $urandom_range(0, 10));
                free_seg(32'hFFFF_FFFF - $urandom_range(0, 40), 32'hFFFF_FFFF);
                free_seg(32'd0, $urandom_range(0, 3));
                take($urandom);
                take(32'hFFFF_FFFF);
                take($urandom_range(1, 8));
            end
            else
            begin
                // noise: any command, full-width fields, inverted frees, zero requests
                cnt = $urandom_range(3, 8);
                for (j = 0; j < cnt; j++)
                    send(CMD_BITS'($urandom_range(0, 3)), $urandom, $urandom,
                         ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
            end
        end

        // Let everything drain, then allow for stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("first_fit_free_segment_allocator_top regression: pass");
        else
            $display("first_fit_free_segment_allocator_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/ffsa_pkg.sv
sv/ffsa_datapath.sv
sv/ffsa_ctrl.sv
sv/first_fit_free_segment_allocator_top.sv
dv/ffsa_checker.sv
dv/tb.sv
